// File: src/ultrasonic_ranger_averaging_defines.svh
// Assertion macros shared by the ranger RTL.
`ifndef ULTRASONIC_RANGER_AVERAGING_DEFINES_SVH
`define ULTRASONIC_RANGER_AVERAGING_DEFINES_SVH

`ifndef SYNTHESIS

`define URA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define URA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define URA_ASSERT(label, clk, rst_n, prop)

`define URA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/ura_pkg.sv
package ura_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned DIST_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DVD_W    = SUM_W + 4;
  localparam int unsigned DIV_W    = 10;

  localparam int unsigned TRIG_LOW_TICKS  = 2;
  localparam int unsigned TRIG_HIGH_TICKS = 10;
  localparam int unsigned US_PER_CM       = 58;
  localparam int unsigned DIST_MAX        = 16383;

  localparam logic [CFG_IDX_W-1:0] REG_READINGS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 2'd2;

  localparam logic [CNT_W-1:0]  RST_READINGS_COUNT = 4'd5;
  localparam logic [TICK_W-1:0] RST_ECHO_TIMEOUT   = 16'd30000;
  localparam logic [TICK_W-1:0] RST_GAP_TICKS      = 16'd5000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: src/ultrasonic_ranger_averaging.sv
// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_stall_o    start_req_i, sensor_sel_i, echo_levels_i
// result   out        out_valid_o / out_stall_i  trigger_lines_o, busy_res_o, done_res_o,
//                                                status_o, distance_o
// config   in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One transaction per microsecond tick, one result per transaction.
// After an accept the sequencer waits in the result state until the result is taken, then accepts again.
// The tick that ends a measurement with a valid echo first passes the divider state: the bit-serial
// divider produces one quotient bit per cycle over a 24-bit dividend.
// Reset clears the sequencer and loads the register defaults (5, 30000, 5000).
// No transaction is accepted while a result waits; out_stall_i holds the result.
`include "ultrasonic_ranger_averaging_defines.svh"

module ultrasonic_ranger_averaging #(
  parameter int unsigned SENSOR_COUNT = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ura_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ura_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            start_req_i,
  input  logic [1:0]                      sensor_sel_i,
  input  logic [SENSOR_COUNT-1:0]         echo_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SENSOR_COUNT-1:0]         trigger_lines_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [1:0]                      status_o,
  output logic [ura_pkg::DIST_W-1:0]      distance_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TLOW,
    PH_THIGH,
    PH_ECHO,
    PH_GAP
  } phase_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_OUT
  } ctl_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_ECHO,
    ST_BAD_SEL
  } status_e;

  localparam int unsigned TW = ura_pkg::TICK_W;
  localparam int unsigned CW = ura_pkg::CNT_W;
  localparam int unsigned SW = ura_pkg::SUM_W;

  logic [CW-1:0] rc_q;
  logic [TW-1:0] tmo_q;
  logic [TW-1:0] gap_q;

  ctl_e          ctl_q;
  phase_e        phase_q, phase_d;
  logic [TW-1:0] ph_ticks_q, ph_ticks_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] vld_q, vld_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [TW-1:0] pulse_q, pulse_d;
  logic          echo_st_q, echo_st_d;
  logic [1:0]    act_q, act_d;

  logic [SENSOR_COUNT-1:0] trig_q, trig_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  status_e                 stat_q, stat_d;
  logic [ura_pkg::DIST_W-1:0] dist_q;

  logic [CW-1:0]           n_w;
  logic [TW-1:0]           tmo_w;
  logic [TW-1:0]           ph_inc_w;
  logic [SENSOR_COUNT-1:0] mask_w;
  logic                    lvl_w;
  logic                    end_rd;
  logic [TW-1:0]           dur;
  logic                    div_go;
  logic                    accept_w;

  ura_pkg::div_sts_t          div_sts;
  logic [ura_pkg::DIST_W-1:0] div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= ura_pkg::RST_READINGS_COUNT;
      tmo_q <= ura_pkg::RST_ECHO_TIMEOUT;
      gap_q <= ura_pkg::RST_GAP_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ura_pkg::REG_READINGS_COUNT: rc_q  <= cfg_data_i[CW-1:0];
        ura_pkg::REG_ECHO_TIMEOUT:   tmo_q <= cfg_data_i[TW-1:0];
        ura_pkg::REG_GAP_TICKS:      gap_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  assign n_w      = (rc_q == '0) ? CW'(1) : rc_q;
  assign tmo_w    = (tmo_q == '0) ? TW'(1) : tmo_q;
  assign ph_inc_w = ph_ticks_q + TW'(1);
  assign mask_w   = SENSOR_COUNT'(1) << act_q;
  assign lvl_w    = |(echo_levels_i & mask_w);
  assign accept_w = in_valid_i && (ctl_q == C_IDLE);

  always_comb begin
    phase_d    = phase_q;
    ph_ticks_d = ph_ticks_q;
    rd_idx_d   = rd_idx_q;
    vld_d      = vld_q;
    sum_d      = sum_q;
    pulse_d    = pulse_q;
    echo_st_d  = echo_st_q;
    act_d      = act_q;
    trig_d     = '0;
    busy_d     = 1'b0;
    done_d     = 1'b0;
    stat_d     = ST_OK;
    end_rd     = 1'b0;
    dur        = '0;
    div_go     = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          if ({2'b00, sensor_sel_i} >= 4'(SENSOR_COUNT)) begin
            done_d = 1'b1;
            stat_d = ST_BAD_SEL;
          end else begin
            act_d      = sensor_sel_i;
            rd_idx_d   = '0;
            vld_d      = '0;
            sum_d      = '0;
            pulse_d    = '0;
            echo_st_d  = 1'b0;
            ph_ticks_d = '0;
            phase_d    = PH_TLOW;
            busy_d     = 1'b1;
          end
        end
      end
      PH_TLOW: begin
        busy_d     = 1'b1;
        ph_ticks_d = ph_inc_w;
        if (ph_inc_w >= TW'(ura_pkg::TRIG_LOW_TICKS)) begin
          phase_d    = PH_THIGH;
          ph_ticks_d = '0;
        end
      end
      PH_THIGH: begin
        busy_d     = 1'b1;
        trig_d     = mask_w;
        ph_ticks_d = ph_inc_w;
        if (ph_inc_w >= TW'(ura_pkg::TRIG_HIGH_TICKS)) begin
          phase_d    = PH_ECHO;
          ph_ticks_d = '0;
          echo_st_d  = 1'b0;
          pulse_d    = '0;
        end
      end
      PH_ECHO: begin
        busy_d     = 1'b1;
        ph_ticks_d = ph_inc_w;
        if (echo_st_q) begin
          if (lvl_w) begin
            pulse_d = pulse_q + TW'(1);
          end else begin
            end_rd = 1'b1;
            dur    = pulse_q;
          end
        end else if (lvl_w) begin
          echo_st_d = 1'b1;
          pulse_d   = TW'(1);
        end
        if (!end_rd && (ph_inc_w >= tmo_w)) begin
          end_rd = 1'b1;
          dur    = '0;
        end
      end
      PH_GAP: begin
        busy_d     = 1'b1;
        ph_ticks_d = ph_inc_w;
        if (ph_inc_w >= gap_q) begin
          phase_d    = PH_TLOW;
          ph_ticks_d = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (end_rd) begin
      if (dur != '0) begin
        sum_d = sum_q + SW'(dur);
        vld_d = vld_q + CW'(1);
      end
      rd_idx_d   = rd_idx_q + CW'(1);
      ph_ticks_d = '0;
      if (rd_idx_d >= n_w) begin
        phase_d = PH_IDLE;
        busy_d  = 1'b0;
        done_d  = 1'b1;
        if (vld_d == '0) begin
          stat_d = ST_NO_ECHO;
        end else begin
          div_go = 1'b1;
        end
      end else begin
        phase_d = (gap_q == '0) ? PH_TLOW : PH_GAP;
      end
    end
  end

  ura_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept_w && div_go),
    .cnt_i   (vld_d),
    .sum_i   (sum_d),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= C_IDLE;
      phase_q    <= PH_IDLE;
      ph_ticks_q <= '0;
      rd_idx_q   <= '0;
      vld_q      <= '0;
      sum_q      <= '0;
      pulse_q    <= '0;
      echo_st_q  <= 1'b0;
      act_q      <= '0;
      trig_q     <= '0;
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      stat_q     <= ST_OK;
      dist_q     <= '0;
    end else begin
      case (ctl_q)
        C_IDLE: begin
          if (in_valid_i) begin
            phase_q    <= phase_d;
            ph_ticks_q <= ph_ticks_d;
            rd_idx_q   <= rd_idx_d;
            vld_q      <= vld_d;
            sum_q      <= sum_d;
            pulse_q    <= pulse_d;
            echo_st_q  <= echo_st_d;
            act_q      <= act_d;
            trig_q     <= trig_d;
            busy_q     <= busy_d;
            done_q     <= done_d;
            stat_q     <= stat_d;
            dist_q     <= '0;
            ctl_q      <= div_go ? C_DIV : C_OUT;
          end
        end
        C_DIV: begin
          if (div_sts.done) begin
            dist_q <= div_quo;
            ctl_q  <= C_OUT;
          end
        end
        C_OUT: begin
          if (!out_stall_i) begin
            ctl_q <= C_IDLE;
          end
        end
        default: begin
          ctl_q <= C_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = (ctl_q != C_IDLE);
  assign out_valid_o     = (ctl_q == C_OUT);
  assign trigger_lines_o = trig_q;
  assign busy_res_o      = busy_q;
  assign done_res_o      = done_q;
  assign status_o        = stat_q;
  assign distance_o      = dist_q;

  `URA_ASSERT(a_hold_input_with_result, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `URA_ASSERT(a_dist_zero_unless_ok, clk_i, rst_ni, (out_valid_o && (status_o != ST_OK)) |-> (distance_o == '0))
  `URA_ASSERT(a_busy_done_exclusive, clk_i, rst_ni, out_valid_o |-> !(busy_res_o && done_res_o))
  `URA_ASSERT_NEXT(a_one_result_per_item, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)

endmodule

// File: src/ura_div.sv
`include "ultrasonic_ranger_averaging_defines.svh"

module ura_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ura_pkg::CNT_W-1:0]   cnt_i,
  input  logic [ura_pkg::SUM_W-1:0]   sum_i,
  output ura_pkg::div_sts_t           sts_o,
  output logic [ura_pkg::DIST_W-1:0]  quo_o
);

  localparam int unsigned STEP_W = $clog2(ura_pkg::DVD_W);

  logic [ura_pkg::DVD_W-1:0]  dvd_q;
  logic [ura_pkg::DIV_W-1:0]  rem_q;
  logic [ura_pkg::DIST_W-1:0] quo_q;
  logic                       ovf_q;
  logic [ura_pkg::CNT_W-1:0]  cnt_q;
  logic [STEP_W-1:0]          step_q;
  logic                       busy_q;
  logic                       done_q;

  logic [ura_pkg::DIV_W-1:0]  divisor_w;
  logic [ura_pkg::DIV_W:0]    rem_sh_w;
  logic [ura_pkg::DIV_W:0]    rem_sub_w;
  logic                       ge_w;

  assign divisor_w = ura_pkg::DIV_W'(cnt_q) * ura_pkg::DIV_W'(ura_pkg::US_PER_CM);
  assign rem_sh_w  = {rem_q, dvd_q[ura_pkg::DVD_W-1]};
  assign ge_w      = rem_sh_w >= {1'b0, divisor_w};
  assign rem_sub_w = rem_sh_w - {1'b0, divisor_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= {sum_i, 4'b0000};
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        cnt_q  <= cnt_i;
        step_q <= STEP_W'(ura_pkg::DVD_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[ura_pkg::DVD_W-2:0], 1'b0};
        rem_q <= ge_w ? rem_sub_w[ura_pkg::DIV_W-1:0] : rem_sh_w[ura_pkg::DIV_W-1:0];
        quo_q <= {quo_q[ura_pkg::DIST_W-2:0], ge_w};
        ovf_q <= ovf_q | quo_q[ura_pkg::DIST_W-1];
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o = ovf_q ? ura_pkg::DIST_W'(ura_pkg::DIST_MAX) : quo_q;

  `URA_ASSERT(a_start_nonzero_count, clk_i, rst_ni, start_i |-> (cnt_i != '0))
  `URA_ASSERT(a_start_when_free, clk_i, rst_ni, start_i |-> !busy_q)
  `URA_ASSERT(a_rem_below_divisor, clk_i, rst_ni, busy_q |-> (rem_q < divisor_w))
  `URA_ASSERT_NEXT(a_done_ends_run, clk_i, rst_ni, busy_q && (step_q == '0) && !start_i, done_q && !busy_q)

endmodule
